/* rtl/bpfc_pkg.sv */
// ----------------------------------------------------------------------------
// bpfc_pkg
// Shared types and constants of the block prefetch frame cache tracker.
// ----------------------------------------------------------------------------
package bpfc_pkg;

	localparam int MAX_FRAMES   = 1024;
	localparam int BLOCK_FRAMES = 8;
	localparam int CACHE_FRAMES = 32;
	localparam int FIFO_DEPTH   = CACHE_FRAMES + BLOCK_FRAMES;

	localparam int FRAME_W = 10;
	localparam int FCNT_W  = FRAME_W + 1;
	localparam int MAP_AW  = $clog2(MAX_FRAMES);
	localparam int BLK_W   = $clog2(BLOCK_FRAMES);
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int OCC_W   = $clog2(FIFO_DEPTH + 1);
	localparam int NLD_W   = $clog2(BLOCK_FRAMES + 1);
	localparam int REM_W   = $clog2(2 * BLOCK_FRAMES + 1);

	typedef enum logic [1:0] {
		ACT_HIT   = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_EVICT = 2'd2,
		ACT_RANGE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RANGE,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_EVAL,
		ST_LOAD,
		ST_EV_RD,
		ST_EV_WR
	} state_t;

	typedef struct packed {
		action_t            action;
		logic [FRAME_W-1:0] frame;
		logic               last;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [MAP_AW-1:0] waddr;
		logic              wdata;
		logic [MAP_AW-1:0] raddr;
	} map_req_t;

	typedef struct packed {
		logic               we;
		logic [FIFO_AW-1:0] waddr;
		logic [FRAME_W-1:0] wdata;
		logic [FIFO_AW-1:0] raddr;
	} fifo_req_t;

endpackage

/* rtl/bpfc_ram.sv */
// ----------------------------------------------------------------------------
// bpfc_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/bpfc_ctrl.sv */
// ----------------------------------------------------------------------------
// bpfc_ctrl
// Sequencer: clears the residency map, scans a block, walks loads and
// evictions one word at a time through the shared counter and FIFO pointers.
// ----------------------------------------------------------------------------
module bpfc_ctrl import bpfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FRAME_W-1:0] frame_index,
	input  logic [FCNT_W-1:0]  frame_count,
	input  logic               map_rdata,
	input  logic [FRAME_W-1:0] fifo_rdata,
	output map_req_t           map_req,
	output fifo_req_t          fifo_req,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res
);

	state_t state_q, state_d;

	logic [MAP_AW-1:0]       clr_q;
	logic [FRAME_W-1:0]      idx_q;
	logic [BLK_W-1:0]        cnt_q;
	logic                    rd_vld_q;
	logic [BLK_W-1:0]        rd_idx_q;
	logic [BLOCK_FRAMES-1:0] mask_q;
	logic                    hit_q;
	logic [REM_W-1:0]        rem_q;
	logic [NLD_W-1:0]        ev_q;
	logic [FIFO_AW-1:0]      head_q;
	logic [FIFO_AW-1:0]      tail_q;
	logic [OCC_W-1:0]        count_q;

	logic [FRAME_W-BLK_W-1:0] blk;
	logic [FRAME_W-1:0]       cur_frame;
	logic [FRAME_W-1:0]       scan_frame;
	logic                     scan_ok;
	logic                     cnt_last;
	logic                     ld_bit;
	logic                     ld_go;
	logic                     ev_go;
	logic                     out_of_range;
	logic [NLD_W-1:0]         n_load;
	logic [OCC_W:0]           occ_sum;
	logic [NLD_W-1:0]         n_evict;

	assign blk          = idx_q[FRAME_W-1:BLK_W];
	assign cur_frame    = {blk, cnt_q};
	assign scan_frame   = {blk, rd_idx_q};
	assign scan_ok      = {1'b0, scan_frame} < frame_count;
	assign cnt_last     = cnt_q == BLK_W'(BLOCK_FRAMES - 1);
	assign ld_bit       = mask_q[cnt_q];
	assign ld_go        = (state_q == ST_LOAD) && ld_bit && res_ready;
	assign ev_go        = (state_q == ST_EV_WR) && res_ready;
	assign out_of_range = {1'b0, frame_index} >= frame_count;
	assign n_load       = NLD_W'($countones(mask_q));
	assign occ_sum      = {1'b0, count_q} + (OCC_W+1)'(n_load);
	assign n_evict      = (occ_sum > (OCC_W+1)'(CACHE_FRAMES))
		? NLD_W'(occ_sum - (OCC_W+1)'(CACHE_FRAMES)) : '0;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == MAP_AW'(MAX_FRAMES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = out_of_range ? ST_RANGE : ST_SCAN;
			end
			ST_RANGE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (cnt_last) state_d = ST_SCAN_WAIT;
			end
			ST_SCAN_WAIT: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!hit_q) state_d = ST_LOAD;
				else if (res_ready) state_d = ST_IDLE;
			end
			ST_LOAD: begin
				if (cnt_last && (!ld_bit || res_ready)) begin
					state_d = (ev_q != '0) ? ST_EV_RD : ST_IDLE;
				end
			end
			ST_EV_RD: state_d = ST_EV_WR;
			ST_EV_WR: begin
				if (res_ready) state_d = (ev_q == NLD_W'(1)) ? ST_IDLE : ST_EV_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		res_valid      = 1'b0;
		res.action     = ACT_HIT;
		res.frame      = idx_q;
		res.last       = 1'b1;
		map_req.we     = 1'b0;
		map_req.waddr  = cur_frame;
		map_req.wdata  = 1'b0;
		map_req.raddr  = cur_frame;
		fifo_req.we    = 1'b0;
		fifo_req.waddr = tail_q;
		fifo_req.wdata = cur_frame;
		fifo_req.raddr = head_q;
		unique case (state_q)
			ST_CLEAR: begin
				map_req.we    = 1'b1;
				map_req.waddr = clr_q;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_RANGE: begin
				res_valid  = 1'b1;
				res.action = ACT_RANGE;
			end
			ST_EVAL: res_valid = hit_q;
			ST_LOAD: begin
				res_valid     = ld_bit;
				res.action    = ACT_LOAD;
				res.frame     = cur_frame;
				res.last      = rem_q == REM_W'(1);
				map_req.we    = ld_go;
				map_req.wdata = 1'b1;
				fifo_req.we   = ld_go;
			end
			ST_EV_WR: begin
				res_valid     = 1'b1;
				res.action    = ACT_EVICT;
				res.frame     = fifo_rdata;
				res.last      = rem_q == REM_W'(1);
				map_req.we    = ev_go;
				map_req.waddr = fifo_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			mask_q   <= '0;
			hit_q    <= 1'b0;
			rem_q    <= '0;
			ev_q     <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= state_q == ST_SCAN;
			rd_idx_q <= cnt_q;
			if (state_q == ST_CLEAR) clr_q <= MAP_AW'(clr_q + 1'b1);
			if (state_q == ST_IDLE && in_valid) begin
				idx_q  <= frame_index;
				cnt_q  <= '0;
				mask_q <= '0;
				hit_q  <= 1'b0;
			end
			if (state_q == ST_SCAN) cnt_q <= cnt_last ? '0 : BLK_W'(cnt_q + 1'b1);
			if (rd_vld_q) begin
				mask_q[rd_idx_q] <= scan_ok && !map_rdata;
				if (rd_idx_q == idx_q[BLK_W-1:0] && map_rdata) hit_q <= 1'b1;
			end
			if (state_q == ST_EVAL) begin
				cnt_q <= '0;
				ev_q  <= n_evict;
				rem_q <= REM_W'(n_load) + REM_W'(n_evict);
			end
			if (state_q == ST_LOAD && (!ld_bit || res_ready)) begin
				cnt_q <= cnt_last ? '0 : BLK_W'(cnt_q + 1'b1);
			end
			if (ld_go) begin
				tail_q  <= (tail_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : FIFO_AW'(tail_q + 1'b1);
				count_q <= OCC_W'(count_q + 1'b1);
				rem_q   <= REM_W'(rem_q - 1'b1);
			end
			if (ev_go) begin
				head_q  <= (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : FIFO_AW'(head_q + 1'b1);
				count_q <= OCC_W'(count_q - 1'b1);
				rem_q   <= REM_W'(rem_q - 1'b1);
				ev_q    <= NLD_W'(ev_q - 1'b1);
			end
		end
	end

endmodule

/* rtl/block_prefetch_fifo_cache_core.sv */
// ----------------------------------------------------------------------------
// block_prefetch_fifo_cache_core
// Residency tracker for a frame cache with block prefetch and FIFO eviction.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-entry residency map, one entry a cycle,
// and takes no request until the clear is done. A request at or beyond
// frame_count answers from the range state without reading the map. Any
// other request first reads the map for the 8 frames of its block, one read
// a cycle through the single map read port; a hit answers there. A miss then
// walks the 8 block slots once, one slot a cycle unless a load word waits on
// the output, with one load word per missing frame, and evicts each victim by
// first reading it from the age FIFO RAM and then clearing its map entry.
// ----------------------------------------------------------------------------
module block_prefetch_fifo_cache_core import bpfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] frame_index, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] frame, [15:10] zero
	output logic [1:0]  m_tuser,   // [1:0] action
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data   // [10:0] frame_count
);

	logic [FCNT_W-1:0]  frame_count_q;
	logic               map_rdata;
	logic [FRAME_W-1:0] fifo_rdata;
	map_req_t           map_req;
	fifo_req_t          fifo_req;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               out_valid_q;
	res_t               out_q;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FCNT_W'(MAX_FRAMES);
		end else if (cfg_valid) begin
			frame_count_q <= cfg_data;
		end
	end

	bpfc_ram #(
		.WIDTH(1),
		.DEPTH(MAX_FRAMES)
	) u_map (
		.clk  (clk),
		.we   (map_req.we),
		.waddr(map_req.waddr),
		.wdata(map_req.wdata),
		.raddr(map_req.raddr),
		.rdata(map_rdata)
	);

	bpfc_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(FIFO_DEPTH)
	) u_age (
		.clk  (clk),
		.we   (fifo_req.we),
		.waddr(fifo_req.waddr),
		.wdata(fifo_req.wdata),
		.raddr(fifo_req.raddr),
		.rdata(fifo_rdata)
	);

	bpfc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.frame_index(s_tdata[FRAME_W-1:0]),
		.frame_count(frame_count_q),
		.map_rdata  (map_rdata),
		.fifo_rdata (fifo_rdata),
		.map_req    (map_req),
		.fifo_req   (fifo_req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16-FRAME_W){1'b0}}, out_q.frame};
	assign m_tuser  = out_q.action;
	assign m_tlast  = out_q.last;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while a request is in work");

	a_word_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid)
		else $error("result word lost before the output register");

	a_fifo_with_map: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_req.we |-> map_req.we && map_req.wdata)
		else $error("age FIFO push without marking the frame resident");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.action == ACT_HIT || res.action == ACT_RANGE) |-> res.last)
		else $error("hit or range word not marked last");

endmodule
